[sv/smm_pkg.sv]
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the square matrix multiplier
// Element width, default matrix size and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package smm_pkg;

    localparam int DATA_W      = 32;  // element and product width
    localparam int IDX_OUT_W   = 2;   // row / column field width on the output
    localparam int DEFAULT_DIM = 3;

    // command from the controller to the datapath
    typedef struct packed {
        logic wr_left;   // write s_tdata into the left store
        logic wr_right;  // write s_tdata into the right store
        logic rd_en;     // read one left/right pair for the MAC pipe
        logic rd_first;  // first term of a dot product
        logic rd_last;   // final term of a dot product
    } cmd_t;

endpackage

[sv/smm_datapath.sv]
// ----------------------------------------------------------------------------
// smm_datapath: element stores and multiply-accumulate pipe
// Two element memories, a registered read, a multiply stage and an
// accumulator that raises sum_valid when a dot product is complete.
// ----------------------------------------------------------------------------
module smm_datapath #(
    parameter int DIM = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  smm_pkg::cmd_t               cmd,
    input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] wr_addr,
    input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_left_addr,
    input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_right_addr,
    input  logic [smm_pkg::DATA_W-1:0]  wr_data,
    output logic                        sum_valid,
    output logic [smm_pkg::DATA_W-1:0]  sum
);
    import smm_pkg::*;

    localparam int CELLS  = DIM * DIM;

    logic [DATA_W-1:0] left_mem  [CELLS];
    logic [DATA_W-1:0] right_mem [CELLS];

    logic [DATA_W-1:0] rd_left_reg, rd_right_reg;
    logic              rd_v_reg, rd_first_reg, rd_last_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              prod_v_reg, prod_first_reg, prod_last_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              sum_v_reg;
    logic [DATA_W-1:0] mul_low;

    // memories: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (cmd.wr_left) begin
            left_mem[wr_addr] <= wr_data;
        end
        if (cmd.wr_right) begin
            right_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_left_reg  <= left_mem[rd_left_addr];
            rd_right_reg <= right_mem[rd_right_addr];
        end
    end

    // low half only: wraps the same for signed and unsigned operands
    assign mul_low = DATA_W'(rd_left_reg * rd_right_reg);

    always_ff @(posedge aclk) begin
        if (rd_v_reg) begin
            prod_reg <= mul_low;
        end
        if (prod_v_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_next = prod_first_reg ? prod_reg : DATA_W'(acc_reg + prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg       <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_v_reg     <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            sum_v_reg      <= 1'b0;
        end else begin
            rd_v_reg       <= cmd.rd_en;
            rd_first_reg   <= cmd.rd_first;
            rd_last_reg    <= cmd.rd_last;
            prod_v_reg     <= rd_v_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
            sum_v_reg      <= prod_v_reg & prod_last_reg;
        end
    end

    assign sum_valid = sum_v_reg;
    assign sum       = acc_reg;

endmodule

[sv/smm_controller.sv]
// ----------------------------------------------------------------------------
// smm_controller: load and compute sequencer
// Counts incoming beats into the two stores, then walks every product
// element, issuing DIM reads per element and presenting each sum on m_*.
// ----------------------------------------------------------------------------
module smm_controller #(
    parameter int DIM = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [smm_pkg::IDX_OUT_W-1:0] out_row,
    output logic [smm_pkg::IDX_OUT_W-1:0] out_column,
    output logic                        out_last,
    output smm_pkg::cmd_t               cmd,
    output logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] wr_addr,
    output logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_left_addr,
    output logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_right_addr,
    input  logic                        sum_valid
);
    import smm_pkg::*;

    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = $clog2(2 * CELLS);
    localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;

    localparam logic [CNT_W-1:0]  CNT_CELLS = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(2 * CELLS - 1);
    localparam logic [DIM_W-1:0]  IDX_LAST  = DIM_W'(DIM - 1);
    localparam logic [ADDR_W-1:0] ADDR_DIM  = ADDR_W'(DIM);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [DIM_W-1:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [ADDR_W-1:0] rbase_reg, rbase_next;
    logic [ADDR_W-1:0] laddr_reg, laddr_next, raddr_reg, raddr_next;
    logic              s_beat, m_beat, is_left, final_elem;

    assign s_tready   = (state_reg == ST_LOAD);
    assign m_tvalid   = (state_reg == ST_OUT);
    assign s_beat     = s_tvalid & s_tready;
    assign m_beat     = m_tvalid & m_tready;
    assign is_left    = (load_cnt_reg < CNT_CELLS);
    assign final_elem = (r_reg == IDX_LAST) && (c_reg == IDX_LAST);

    assign wr_addr = is_left ? ADDR_W'(load_cnt_reg) : ADDR_W'(load_cnt_reg - CNT_CELLS);
    assign rd_left_addr  = laddr_reg;
    assign rd_right_addr = raddr_reg;

    assign cmd.wr_left  = s_beat & is_left;
    assign cmd.wr_right = s_beat & ~is_left;
    assign cmd.rd_en    = (state_reg == ST_ISSUE);
    assign cmd.rd_first = (state_reg == ST_ISSUE) && (k_reg == '0);
    assign cmd.rd_last  = (state_reg == ST_ISSUE) && (k_reg == IDX_LAST);

    assign out_row    = IDX_OUT_W'(r_reg);
    assign out_column = IDX_OUT_W'(c_reg);
    assign out_last   = final_elem;

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        rbase_next    = rbase_reg;
        laddr_next    = laddr_reg;
        raddr_next    = raddr_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_beat) begin
                    if (load_cnt_reg == CNT_LAST) begin
                        load_cnt_next = '0;
                        state_next    = ST_ISSUE;
                        r_next        = '0;
                        c_next        = '0;
                        k_next        = '0;
                        rbase_next    = '0;
                        laddr_next    = '0;
                        raddr_next    = '0;
                    end else begin
                        load_cnt_next = CNT_W'(load_cnt_reg + 1'b1);
                    end
                end
            end
            ST_ISSUE: begin
                if (k_reg == IDX_LAST) begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end else begin
                    k_next     = DIM_W'(k_reg + 1'b1);
                    laddr_next = ADDR_W'(laddr_reg + 1'b1);
                    raddr_next = ADDR_W'(raddr_reg + ADDR_DIM);
                end
            end
            ST_WAIT: begin
                if (sum_valid) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_beat) begin
                    if (final_elem) begin
                        state_next = ST_LOAD;
                    end else if (c_reg == IDX_LAST) begin
                        state_next = ST_ISSUE;
                        c_next     = '0;
                        r_next     = DIM_W'(r_reg + 1'b1);
                        rbase_next = ADDR_W'(rbase_reg + ADDR_DIM);
                        laddr_next = ADDR_W'(rbase_reg + ADDR_DIM);
                        raddr_next = '0;
                    end else begin
                        state_next = ST_ISSUE;
                        c_next     = DIM_W'(c_reg + 1'b1);
                        laddr_next = rbase_reg;
                        raddr_next = ADDR_W'(c_reg + 1'b1);
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            rbase_reg    <= '0;
            laddr_reg    <= '0;
            raddr_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            rbase_reg    <= rbase_next;
            laddr_reg    <= laddr_next;
            raddr_reg    <= raddr_next;
        end
    end

endmodule

[sv/square_matrix_multiply.sv]
// ----------------------------------------------------------------------------
// square_matrix_multiply: DIM x DIM integer matrix product
// Loads a left and a right matrix beat by beat, then streams out the product.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one 32-bit element per beat: DIM*DIM left elements, then
//   DIM*DIM right elements, both row-major. Loading takes one beat a cycle.
//   After the last right element, s_tready drops and the block walks the
//   product in row-major order. Each product element issues DIM store reads
//   on the shared multiply-accumulate pipe, passes the read, multiply and
//   accumulate registers, then waits for its beat on m_*; the next element's
//   reads start only once the current one is taken.
//   m_tdata holds the wrapped 32-bit sum, m_tuser its row and column, and
//   m_tlast marks the final element. A stalled m_tready simply holds the
//   current element and the sequencer waits; nothing is lost.
//   s_tready returns high the cycle after the final beat on m_* is taken.
//   Reset (aresetn low, synchronous) empties the pipe and restarts loading
//   at the first left element; store contents are not cleared.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
    parameter int DIM = smm_pkg::DEFAULT_DIM
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [smm_pkg::DATA_W-1:0]   s_tdata,   // [31:0] element
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [smm_pkg::DATA_W-1:0]   m_tdata,   // [31:0] product_element
    output logic [2*smm_pkg::IDX_OUT_W-1:0] m_tuser, // [1:0] row, [3:2] column
    output logic                         m_tlast
);
    import smm_pkg::*;

    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    cmd_t                  cmd;
    logic [ADDR_W-1:0]     wr_addr, rd_left_addr, rd_right_addr;
    logic                  sum_valid;
    logic [IDX_OUT_W-1:0]  out_row, out_column;

    smm_controller #(
        .DIM (DIM)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .out_row       (out_row),
        .out_column    (out_column),
        .out_last      (m_tlast),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .sum_valid     (sum_valid)
    );

    smm_datapath #(
        .DIM (DIM)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .wr_data       (s_tdata),
        .sum_valid     (sum_valid),
        .sum           (m_tdata)
    );

    assign m_tuser = {out_column, out_row};

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the square matrix multiplier
// Feeds pairs of matrices element by element and holds its own copy of both
// element stores. At each completed pair it works out the product and checks
// every output beat against it in order. The sender runs in random bursts and
// the receiver stalls on its own pattern, with one long receiver hold-off and
// one sender pause until the block has drained.
// ----------------------------------------------------------------------------
module tb_top;

    import smm_pkg::*;

    localparam int N          = DEFAULT_DIM;
    localparam int CELLS      = N * N;
    localparam int PAIRS      = 19;        // random matrix pairs after the directed one
    localparam int DRAIN_PAIR = 10;        // sender waits for an empty pipe before this one
    localparam int HOLD_AT    = 60;        // input beat count that starts the long hold-off
    localparam int LONG_HOLD  = 400;
    localparam int TAIL       = 40;        // cycles allowed after the last product

    typedef enum logic [1:0] {
        RX_FULL,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_e;

    typedef struct {
        logic [DATA_W-1:0] value;
        bit                after_drain;
    } element_beat_t;

    typedef struct {
        logic [DATA_W-1:0]    value;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 last;
    } product_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [DATA_W-1:0]         s_tdata  = '0;   // [31:0] element
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [DATA_W-1:0]         m_tdata;         // [31:0] product_element
    logic [2*IDX_OUT_W-1:0]    m_tuser;         // [1:0] row, [3:2] column
    logic                      m_tlast;

    element_beat_t element_feed[$];
    product_t      product_queue[$];

    logic [DATA_W-1:0] left_mat  [CELLS];
    logic [DATA_W-1:0] right_mat [CELLS];
    int                load_cnt     = 0;
    int                error_count  = 0;
    int                result_count = 0;

    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_e rx_mode    = RX_FULL;
    int       mode_left  = 0;
    int       hold_left  = 0;
    int       in_beats   = 0;

    square_matrix_multiply #(.DIM(N)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    // stores one accepted element; the last right element yields the product
    task automatic absorb_element(input logic [DATA_W-1:0] v);
        product_t          p;
        logic [DATA_W-1:0] acc;
        if (load_cnt < CELLS) begin
            left_mat[load_cnt] = v;
        end else begin
            right_mat[load_cnt - CELLS] = v;
        end
        load_cnt++;
        if (load_cnt == 2 * CELLS) begin
            load_cnt = 0;
            for (int r = 0; r < N; r++) begin
                for (int c = 0; c < N; c++) begin
                    acc = '0;
                    for (int k = 0; k < N; k++) begin
                        acc = acc + left_mat[r*N + k] * right_mat[k*N + c];
                    end
                    p.value = acc;
                    p.row   = IDX_OUT_W'(r);
                    p.col   = IDX_OUT_W'(c);
                    p.last  = (r == N - 1) && (c == N - 1);
                    product_queue.push_back(p);
                end
            end
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_element();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = DATA_W'($signed($urandom_range(0, 32)) - 16);
            7:             v = {1'b0, {(DATA_W-1){1'b1}}};
            8:             v = {1'b1, {(DATA_W-1){1'b0}}};
            default:       v = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return v;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_element(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (element_feed.size() == 0 ||
                             (element_feed[0].after_drain && product_queue.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= element_feed[0].value;
                    s_tvalid <= 1'b1;
                    element_feed.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off while the sender keeps going
    always @(posedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_beats++;
                if (in_beats == HOLD_AT) hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(5, 60);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FULL:   rdy = 1'b1;
                RX_RANDOM: rdy = 1'($urandom_range(0, 1));
                default:   rdy = ($urandom_range(0, 3) == 0);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    // monitor
    always @(posedge aclk) begin
        product_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (product_queue.size() == 0) begin
                flag_error($sformatf("unexpected product beat: data %h user %h last %b",
                                     m_tdata, m_tuser, m_tlast));
            end else begin
                w = product_queue.pop_front();
                if (m_tdata !== w.value)
                    flag_error($sformatf("product %0d data: got %h, want %h",
                                         result_count, m_tdata, w.value));
                if (m_tuser[IDX_OUT_W-1:0] !== w.row)
                    flag_error($sformatf("product %0d row: got %0d, want %0d",
                                         result_count, m_tuser[IDX_OUT_W-1:0], w.row));
                if (m_tuser[2*IDX_OUT_W-1:IDX_OUT_W] !== w.col)
                    flag_error($sformatf("product %0d column: got %0d, want %0d",
                                         result_count, m_tuser[2*IDX_OUT_W-1:IDX_OUT_W],
                                         w.col));
                if (m_tlast !== w.last)
                    flag_error($sformatf("product %0d last: got %b, want %b",
                                         result_count, m_tlast, w.last));
            end
            result_count++;
        end
    end

    initial begin
        element_beat_t b;
        logic [DATA_W-1:0] directed [2*CELLS];
        int waited;

        // extremes and wrap-around: max*max, min*min, min*-1 and mixed signs
        directed = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFE,
                     32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                     32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h5555_AAAA};
        for (int i = 0; i < 2*CELLS; i++) begin
            b.value       = directed[i];
            b.after_drain = 1'b0;
            element_feed.push_back(b);
        end
        for (int p = 0; p < PAIRS; p++) begin
            for (int i = 0; i < 2*CELLS; i++) begin
                b.value       = pick_element();
                b.after_drain = (p == DRAIN_PAIR) && (i == 0);
                element_feed.push_back(b);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (element_feed.size() != 0 || s_tvalid);
        waited = 0;
        while (product_queue.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL) @(posedge aclk);
        if (product_queue.size() != 0)
            flag_error($sformatf("%0d products never arrived", product_queue.size()));

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
sv/smm_pkg.sv
sv/smm_datapath.sv
sv/smm_controller.sv
sv/square_matrix_multiply.sv
tb/tb_top.sv
